// ----- rtl/core/ubsd_pkg.sv -----
// Types and constants shared by the byte stream decoder and its channels.
// No dependencies.
`default_nettype none

package ubsd_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned AddrW = 3;

  // encoding selected by the mode register
  typedef enum logic [1:0] {
    MODE_UTF8    = 2'd0,
    MODE_UTF16LE = 2'd1,
    MODE_UTF16BE = 2'd2,
    MODE_USER    = 2'd3
  } mode_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_MODE       = 1'b0,
    REG_IGNORE_BOM = 1'b1
  } reg_idx_e;

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CpW-1:0] BOM_CP         = 21'h00FEFF;
  localparam logic [CpW-1:0] USER_BASE_CP   = 21'h00F700;  // 0xF780 - 0x80
  localparam logic [CpW-1:0] SUPP_BASE_CP   = 21'h010000;
  localparam logic [7:0]     CONT_LO        = 8'h80;
  localparam logic [7:0]     CONT_HI        = 8'hBF;

  // one code point produced while decoding an item
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] cp;
    logic           err;
  } emit_t;

  // outcome of a UTF-8 byte taken as the start of a sequence
  typedef struct packed {
    emit_t           e;
    logic [1:0]      need;
    logic [CpW-1:0]  partial;
    logic [7:0]      lo;
    logic [7:0]      hi;
  } lead_t;

  // one queued result transfer
  typedef struct packed {
    logic [CpW-1:0] cp_value;
    logic           decode_error;
    logic           last_of_run;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ubsd_if.sv -----
// Valid/ready channels of the byte stream decoder: input bytes and code points.
// Depends on ubsd_pkg.
`default_nettype none

interface ubsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       end_of_stream;

  modport source (output valid, byte_value, byte_present, end_of_stream, input ready);
  modport sink   (input valid, byte_value, byte_present, end_of_stream, output ready);
endinterface

interface ubsd_cp_if;
  import ubsd_pkg::*;
  logic           valid;
  logic           ready;
  logic [CpW-1:0] cp_value;
  logic           decode_error;
  logic           last_of_run;

  modport source (output valid, cp_value, decode_error, last_of_run, input ready);
  modport sink   (input valid, cp_value, decode_error, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/unicode_byte_stream_decoder.sv -----
// Byte stream to Unicode code point decoder (UTF-8, UTF-16LE/BE, x-user-defined).
// Depends on ubsd_pkg and the channel interfaces in ubsd_if.sv.
//
// One byte is taken per transfer on item_i and decoded in the same cycle
// against the sequence state; the zero, one or two code points it yields are
// written into a four-entry result queue that drives result_o from the next
// cycle on. An item is taken in every cycle while the queue has room for two
// results, so the rate is one byte per cycle as long as result_o keeps up;
// an item yielding two code points needs a result_o transfer for each, and
// the output side then sets the pace. Malformed input gives U+FFFD with
// decode_error set; end_of_stream flushes an unfinished sequence as U+FFFD
// and rearms stripping of a leading byte order mark. Writing the mode
// register restarts the stream.
`default_nettype none

module unicode_byte_stream_decoder (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  ubsd_byte_if.sink                     item_i,
  ubsd_cp_if.source                     result_o,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [ubsd_pkg::AddrW-1:0]    paddr,
  input  wire  [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ubsd_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // configuration
  mode_e mode_q, mode_d;
  logic  ign_q, ign_d;

  // sequence state
  logic [CpW-1:0] partial_q, partial_d;
  logic [1:0]     need_q, need_d;
  logic [1:0]     seen_q, seen_d;
  logic [7:0]     lo_q, lo_d;
  logic [7:0]     hi_q, hi_d;
  logic [7:0]     held_q, held_d;
  logic           held_v_q, held_v_d;
  logic [9:0]     lead_q, lead_d;
  logic           lead_v_q, lead_v_d;
  logic           start_q, start_d;

  // result queue
  result_t          queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  logic      in_fire, out_fire, cfg_wr;
  result_t   res [2];
  logic [1:0] res_n;

  assign in_fire  = item_i.valid & item_i.ready;
  assign out_fire = result_o.valid & result_o.ready;
  assign cfg_wr   = psel & penable & pwrite;

  // UTF-8 byte taken as the start of a new sequence
  function automatic lead_t utf8_lead(input logic [7:0] b);
    lead_t r;
    r.e       = '0;
    r.need    = 2'd0;
    r.partial = '0;
    r.lo      = CONT_LO;
    r.hi      = CONT_HI;
    if (b <= 8'h7F) begin
      r.e = '{valid: 1'b1, cp: {13'b0, b}, err: 1'b0};
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      r.need    = 2'd1;
      r.partial = {16'b0, b[4:0]};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      r.need    = 2'd2;
      r.partial = {17'b0, b[3:0]};
      if (b == 8'hE0) r.lo = 8'hA0;
      if (b == 8'hED) r.hi = 8'h9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      r.need    = 2'd3;
      r.partial = {18'b0, b[2:0]};
      if (b == 8'hF0) r.lo = 8'h90;
      if (b == 8'hF4) r.hi = 8'h8F;
    end else begin
      r.e = '{valid: 1'b1, cp: REPLACEMENT_CP, err: 1'b1};
    end
    return r;
  endfunction

  // decode one item: state update and up to two results
  always_comb begin : decode_comb
    emit_t       cand [3];
    lead_t       ld;
    logic [7:0]  b;
    logic [15:0] unit;
    logic [1:0]  seen_inc;
    logic        bom_arm;
    logic        keep;
    logic        pending;

    b        = item_i.byte_value;
    unit     = '0;
    seen_inc = seen_q + 2'd1;
    pending  = 1'b0;
    keep     = 1'b0;
    ld       = utf8_lead(b);
    for (int i = 0; i < 3; i++) cand[i] = '0;

    mode_d    = mode_q;
    ign_d     = ign_q;
    partial_d = partial_q;
    need_d    = need_q;
    seen_d    = seen_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    lead_d    = lead_q;
    lead_v_d  = lead_v_q;
    start_d   = start_q;

    // byte decode
    if (in_fire && item_i.byte_present) begin
      case (mode_q)
        MODE_UTF8: begin
          if (need_q == 2'd0) begin
            cand[0]   = ld.e;
            need_d    = ld.need;
            partial_d = ld.partial;
            lo_d      = ld.lo;
            hi_d      = ld.hi;
          end else if (b < lo_q || b > hi_q) begin
            // offending byte: replacement, then the byte starts over
            cand[0]   = '{valid: 1'b1, cp: REPLACEMENT_CP, err: 1'b1};
            cand[1]   = ld.e;
            need_d    = ld.need;
            partial_d = ld.partial;
            lo_d      = ld.lo;
            hi_d      = ld.hi;
            seen_d    = 2'd0;
          end else begin
            lo_d      = CONT_LO;
            hi_d      = CONT_HI;
            partial_d = {partial_q[CpW-7:0], b[5:0]};
            seen_d    = seen_inc;
            if (seen_inc == need_q) begin
              cand[0]   = '{valid: 1'b1, cp: partial_d, err: 1'b0};
              partial_d = '0;
              need_d    = 2'd0;
              seen_d    = 2'd0;
            end
          end
        end
        MODE_USER: begin
          cand[0] = '{valid: 1'b1,
                      cp: b[7] ? USER_BASE_CP + {13'b0, b} : {13'b0, b},
                      err: 1'b0};
        end
        default: begin
          // UTF-16: pair bytes into a unit, then pair surrogates
          if (!held_v_q) begin
            held_d   = b;
            held_v_d = 1'b1;
          end else begin
            unit     = (mode_q == MODE_UTF16BE) ? {held_q, b} : {b, held_q};
            held_d   = '0;
            held_v_d = 1'b0;
            if (lead_v_q && unit[15:10] == 6'b110111) begin
              lead_v_d = 1'b0;
              cand[0]  = '{valid: 1'b1,
                           cp: SUPP_BASE_CP + {1'b0, lead_q, unit[9:0]},
                           err: 1'b0};
            end else begin
              // unpaired lead gives a replacement; the unit is decoded anew
              if (lead_v_q) begin
                cand[0] = '{valid: 1'b1, cp: REPLACEMENT_CP, err: 1'b1};
              end
              lead_v_d = 1'b0;
              if (unit[15:10] == 6'b110110) begin
                lead_d   = unit[9:0];
                lead_v_d = 1'b1;
              end else if (unit[15:10] == 6'b110111) begin
                cand[1] = '{valid: 1'b1, cp: REPLACEMENT_CP, err: 1'b1};
              end else begin
                cand[1] = '{valid: 1'b1, cp: {5'b0, unit}, err: 1'b0};
              end
            end
          end
        end
      endcase
    end

    // end of stream flush
    if (in_fire && item_i.end_of_stream) begin
      case (mode_q)
        MODE_UTF8: pending = (need_d != 2'd0);
        MODE_USER: pending = 1'b0;
        default:   pending = held_v_d | lead_v_d;
      endcase
      partial_d = '0;
      need_d    = 2'd0;
      seen_d    = 2'd0;
      lo_d      = CONT_LO;
      hi_d      = CONT_HI;
      held_d    = '0;
      held_v_d  = 1'b0;
      lead_d    = '0;
      lead_v_d  = 1'b0;
      cand[2]   = '{valid: pending, cp: REPLACEMENT_CP, err: 1'b1};
    end

    // byte order mark stripping and packing of the results
    bom_arm = (mode_q != MODE_USER) && !ign_q;
    res_n   = 2'd0;
    res[0]  = '0;
    res[1]  = '0;
    for (int i = 0; i < 3; i++) begin
      if (cand[i].valid) begin
        keep = 1'b1;
        if (bom_arm && start_d) begin
          start_d = 1'b0;
          if (cand[i].cp == BOM_CP) keep = 1'b0;
        end
        if (keep && res_n != 2'd2) begin
          res[res_n[0]] = '{cp_value: cand[i].cp, decode_error: cand[i].err,
                            last_of_run: 1'b0};
          res_n = res_n + 2'd1;
        end
      end
    end
    res[0].last_of_run = (res_n == 2'd1);
    res[1].last_of_run = 1'b1;
    if (in_fire && item_i.end_of_stream) start_d = 1'b1;

    // register writes; a mode write restarts the stream
    if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_MODE: begin
          mode_d    = mode_e'(pwdata[1:0]);
          partial_d = '0;
          need_d    = 2'd0;
          seen_d    = 2'd0;
          lo_d      = CONT_LO;
          hi_d      = CONT_HI;
          held_d    = '0;
          held_v_d  = 1'b0;
          lead_d    = '0;
          lead_v_d  = 1'b0;
          start_d   = 1'b1;
        end
        REG_IGNORE_BOM: ign_d = pwdata[0];
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_UTF8;
      ign_q     <= 1'b0;
      partial_q <= '0;
      need_q    <= 2'd0;
      seen_q    <= 2'd0;
      lo_q      <= CONT_LO;
      hi_q      <= CONT_HI;
      held_q    <= '0;
      held_v_q  <= 1'b0;
      lead_q    <= '0;
      lead_v_q  <= 1'b0;
      start_q   <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      ign_q     <= ign_d;
      partial_q <= partial_d;
      need_q    <= need_d;
      seen_q    <= seen_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      held_q    <= held_d;
      held_v_q  <= held_v_d;
      lead_q    <= lead_d;
      lead_v_q  <= lead_v_d;
      start_q   <= start_d;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(res_n);
      if (out_fire) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_q + (QPtrW+1)'(res_n) - (QPtrW+1)'(out_fire);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (res_n != 2'd0) queue_q[wr_ptr_q] <= res[0];
    if (res_n == 2'd2) queue_q[wr_ptr_q + QPtrW'(1)] <= res[1];
  end

  // take an item only with room for two results
  assign item_i.ready = (cnt_q <= (QPtrW+1)'(QDepth - 2));

  assign result_o.valid        = (cnt_q != '0);
  assign result_o.cp_value     = queue_q[rd_ptr_q].cp_value;
  assign result_o.decode_error = queue_q[rd_ptr_q].decode_error;
  assign result_o.last_of_run  = queue_q[rd_ptr_q].last_of_run;

  // register read
  assign pready = 1'b1;
  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_MODE:       prdata = {30'b0, mode_q};
      REG_IGNORE_BOM: prdata = {31'b0, ign_q};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/ubsd_decode_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the byte stream decoder: predicts the code points of every byte transfer
// and compares them with the result channel. Depends on ubsd_pkg and ubsd_if.sv.

module ubsd_decode_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ubsd_byte_if                       byte_mon,
  ubsd_cp_if                         cp_mon,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [ubsd_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  import ubsd_pkg::*;

  localparam int unsigned MaxReports = 40;

  // shadow registers
  mode_e          mode_q;
  logic           keep_bom_q;

  // sequence state
  logic [CpW-1:0] acc_q;
  logic [1:0]     need_q;
  logic [1:0]     seen_q;
  logic [7:0]     lo_q;
  logic [7:0]     hi_q;
  logic [7:0]     held_q;
  logic           held_vld_q;
  logic [9:0]     lead_q;
  logic           lead_vld_q;
  logic           fresh_q;  // no code point checked for a leading BOM yet in this stream

  // code points of the byte being decoded, and those still owed by the block
  result_t        run_buf [2];
  int             run_cnt;
  result_t        owed_q [$];

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void clear_seq();
    acc_q      = '0;
    need_q     = '0;
    seen_q     = '0;
    lo_q       = CONT_LO;
    hi_q       = CONT_HI;
    held_q     = '0;
    held_vld_q = 1'b0;
    lead_q     = '0;
    lead_vld_q = 1'b0;
  endfunction

  // first code point of a stream may be a BOM to drop
  function automatic void push_cp(input logic [CpW-1:0] cp, input logic err);
    if (mode_q != MODE_USER && !keep_bom_q && fresh_q) begin
      fresh_q = 1'b0;
      if (cp == BOM_CP) return;
    end
    if (run_cnt < 2) begin
      run_buf[run_cnt] = '{cp_value: cp, decode_error: err, last_of_run: 1'b0};
      run_cnt++;
    end
  endfunction

  function automatic void utf8_step(input logic [7:0] b);
    logic [CpW-1:0] cp;
    for (int pass = 0; pass < 2; pass++) begin
      if (need_q == 2'd0) begin
        if (b <= 8'h7F) begin
          push_cp(CpW'(b), 1'b0);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          need_q = 2'd1;
          acc_q  = CpW'(b[4:0]);
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          if (b == 8'hE0) lo_q = 8'hA0;
          if (b == 8'hED) hi_q = 8'h9F;
          need_q = 2'd2;
          acc_q  = CpW'(b[3:0]);
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          if (b == 8'hF0) lo_q = 8'h90;
          if (b == 8'hF4) hi_q = 8'h8F;
          need_q = 2'd3;
          acc_q  = CpW'(b[2:0]);
        end else begin
          push_cp(REPLACEMENT_CP, 1'b1);
        end
        return;
      end
      if (b < lo_q || b > hi_q) begin
        // bad continuation: replace, then take the byte as a new lead
        clear_seq();
        push_cp(REPLACEMENT_CP, 1'b1);
      end else begin
        lo_q   = CONT_LO;
        hi_q   = CONT_HI;
        acc_q  = {acc_q[CpW-7:0], b[5:0]};
        seen_q = seen_q + 2'd1;
        if (seen_q == need_q) begin
          cp = acc_q;
          clear_seq();
          push_cp(cp, 1'b0);
        end
        return;
      end
    end
  endfunction

  function automatic void utf16_step(input logic [7:0] b);
    logic [15:0] unit;
    if (!held_vld_q) begin
      held_q     = b;
      held_vld_q = 1'b1;
      return;
    end
    unit       = (mode_q == MODE_UTF16BE) ? {held_q, b} : {b, held_q};
    held_vld_q = 1'b0;
    held_q     = '0;
    if (lead_vld_q) begin
      lead_vld_q = 1'b0;
      if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
        push_cp(SUPP_BASE_CP + {1'b0, lead_q, unit[9:0]}, 1'b0);
        return;
      end
      // unpaired lead; this unit is decoded on its own below
      push_cp(REPLACEMENT_CP, 1'b1);
    end
    if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
      lead_q     = unit[9:0];
      lead_vld_q = 1'b1;
    end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
      push_cp(REPLACEMENT_CP, 1'b1);
    end else begin
      push_cp(CpW'(unit), 1'b0);
    end
  endfunction

  function automatic void decode_item(input logic [7:0] b, input logic present,
                                      input logic eos);
    logic unfinished;
    run_cnt = 0;
    if (present) begin
      case (mode_q)
        MODE_UTF8: utf8_step(b);
        MODE_USER: push_cp(b[7] ? USER_BASE_CP + CpW'(b) : CpW'(b), 1'b0);
        default:   utf16_step(b);
      endcase
    end
    // flush and start a new stream
    if (eos) begin
      case (mode_q)
        MODE_UTF8: unfinished = (need_q != 2'd0);
        MODE_USER: unfinished = 1'b0;
        default:   unfinished = held_vld_q || lead_vld_q;
      endcase
      clear_seq();
      if (unfinished) push_cp(REPLACEMENT_CP, 1'b1);
      fresh_q = 1'b1;
    end
    if (run_cnt > 0) run_buf[run_cnt-1].last_of_run = 1'b1;
    for (int i = 0; i < run_cnt; i++) owed_q = {owed_q, run_buf[i]};
  endfunction

  // register writes, result compare, then prediction of the new byte
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mode_q       = MODE_UTF8;
      keep_bom_q   = 1'b0;
      clear_seq();
      fresh_q      = 1'b1;
      owed_q.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_MODE: begin
            mode_q = mode_e'(pwdata_i[1:0]);
            clear_seq();
            fresh_q = 1'b1;
          end
          REG_IGNORE_BOM: keep_bom_q = pwdata_i[0];
          default: ;
        endcase
      end

      if (cp_mon.valid && cp_mon.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected code point %h err %b last %b",
                                    cp_mon.cp_value, cp_mon.decode_error,
                                    cp_mon.last_of_run));
        end else begin
          want = owed_q.pop_front();
          if (cp_mon.cp_value !== want.cp_value)
            report_mismatch($sformatf("cp_value got %h want %h",
                                      cp_mon.cp_value, want.cp_value));
          if (cp_mon.decode_error !== want.decode_error)
            report_mismatch($sformatf("decode_error got %b want %b (cp %h)",
                                      cp_mon.decode_error, want.decode_error,
                                      want.cp_value));
          if (cp_mon.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run got %b want %b (cp %h)",
                                      cp_mon.last_of_run, want.last_of_run,
                                      want.cp_value));
        end
      end

      if (byte_mon.valid && byte_mon.ready)
        decode_item(byte_mon.byte_value, byte_mon.byte_present, byte_mon.end_of_stream);

      pending_o <= owed_q.size();
    end
  end

endmodule

// ----- verif/unicode_byte_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the byte stream decoder: clock, reset, register writes and byte traffic.
// Depends on ubsd_pkg, ubsd_if.sv, the decoder RTL and ubsd_decode_checker.

module unicode_byte_stream_decoder_tb;
  import ubsd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int HoldOff     = 300;
  localparam int DrainCycles = 8;
  localparam int PhaseBytes  = 150;
  localparam int NumPhases   = 8;

  typedef logic [7:0] byte_q_t [$];

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int cycle_count = 0;
  int pending;
  int fail_count;
  int bytes_sent  = 0;
  int rx_hold     = 0;
  bit tx_eager    = 1'b0;
  bit rx_eager    = 1'b0;

  ubsd_byte_if byte_ch ();
  ubsd_cp_if   cp_ch ();

  unicode_byte_stream_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (byte_ch),
    .result_o (cp_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ubsd_decode_checker decode_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_mon     (byte_ch),
    .cp_mon       (cp_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL unicode_byte_stream_decoder");
      $finish;
    end
  end

  // code point sink with random stalls and one long hold-off on request
  initial begin : result_sink
    int stall;
    int taken;
    cp_ch.ready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 64 == 0) rx_eager = ($urandom_range(0, 3) == 0);
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        cp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!cp_ch.valid);
      taken++;
    end
  end

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop offering bytes and let every owed code point drain
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic start_stream(input mode_e mode, input bit keep_bom);
    wait_idle();
    apb_write(REG_IGNORE_BOM, 32'(keep_bom));
    apb_write(REG_MODE, 32'(mode));
  endtask

  task automatic send_byte(input logic [7:0] b, input bit present, input bit eos);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.byte_value    <= b;
    byte_ch.byte_present  <= present;
    byte_ch.end_of_stream <= eos;
    do @(posedge clk_i); while (!byte_ch.ready);
    if (present) bytes_sent++;
  endtask

  task automatic send_seq(input byte_q_t seq, input bit eos_last);
    foreach (seq[i]) send_byte(seq[i], 1'b1, eos_last && (i == seq.size() - 1));
  endtask

  function automatic byte_q_t utf8_encode(input int unsigned cp);
    byte_q_t q;
    if (cp < 'h80) begin
      q = {q, 8'(cp)};
    end else if (cp < 'h800) begin
      q = {q, 8'hC0 | 8'(cp >> 6)};
      q = {q, 8'h80 | 8'(cp & 'h3F)};
    end else if (cp < 'h10000) begin
      q = {q, 8'hE0 | 8'(cp >> 12)};
      q = {q, 8'h80 | 8'((cp >> 6) & 'h3F)};
      q = {q, 8'h80 | 8'(cp & 'h3F)};
    end else begin
      q = {q, 8'hF0 | 8'(cp >> 18)};
      q = {q, 8'h80 | 8'((cp >> 12) & 'h3F)};
      q = {q, 8'h80 | 8'((cp >> 6) & 'h3F)};
      q = {q, 8'h80 | 8'(cp & 'h3F)};
    end
    return q;
  endfunction

  function automatic void push_unit(ref byte_q_t q, input logic [15:0] unit, input bit be);
    if (be) begin
      q = {q, unit[15:8]};
      q = {q, unit[7:0]};
    end else begin
      q = {q, unit[7:0]};
      q = {q, unit[15:8]};
    end
  endfunction

  function automatic int unsigned pick_bmp();
    int unsigned cp;
    case ($urandom_range(0, 5))
      0:       cp = BOM_CP;
      1:       cp = $urandom_range(0, 'h7F);
      2:       cp = $urandom_range('hE000, 'hFFFF);
      default: cp = $urandom_range(0, 'hFFFF);
    endcase
    if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h1000;
    return cp;
  endfunction

  // mostly well-formed text with random content, the rest broken or noise
  function automatic void make_chunk(input mode_e mode, ref byte_q_t q);
    int unsigned cp;
    int unsigned v;
    int          n;
    bit          be;
    be = (mode == MODE_UTF16BE);
    case (mode)
      MODE_UTF8: begin
        case ($urandom_range(0, 9))
          7: begin
            // sequence cut short
            q = utf8_encode($urandom_range('h800, 'h10FFFF));
            void'(q.pop_back());
          end
          8: begin
            // bad continuation, or an encoded surrogate
            if ($urandom_range(0, 1)) begin
              q = utf8_encode($urandom_range('hD800, 'hDFFF));
            end else begin
              q = utf8_encode($urandom_range('h80, 'h10FFFF));
              q[$urandom_range(1, q.size() - 1)] = 8'($urandom_range(0, 255));
            end
          end
          9: begin
            n = $urandom_range(1, 3);
            repeat (n) q = {q, 8'($urandom_range(0, 255))};
          end
          default: begin
            case ($urandom_range(0, 4))
              0:       cp = $urandom_range(0, 'h7F);
              1:       cp = $urandom_range('h80, 'h7FF);
              2:       cp = pick_bmp() | 'h800;
              3:       cp = $urandom_range('h10000, 'h10FFFF);
              default: cp = BOM_CP;
            endcase
            q = utf8_encode(cp);
          end
        endcase
      end
      MODE_UTF16LE, MODE_UTF16BE: begin
        case ($urandom_range(0, 9))
          6, 7: begin
            v = $urandom_range(0, 'hFFFFF);
            push_unit(q, 16'hD800 | 16'(v >> 10), be);
            push_unit(q, 16'hDC00 | 16'(v & 'h3FF), be);
          end
          8: begin
            case ($urandom_range(0, 2))
              0: push_unit(q, 16'($urandom_range('hDC00, 'hDFFF)), be);
              1: begin
                push_unit(q, 16'($urandom_range('hD800, 'hDBFF)), be);
                push_unit(q, 16'(pick_bmp()), be);
              end
              default: begin
                push_unit(q, 16'($urandom_range('hD800, 'hDBFF)), be);
                push_unit(q, 16'($urandom_range('hD800, 'hDBFF)), be);
              end
            endcase
          end
          9: begin
            // odd counts shift the unit alignment
            n = $urandom_range(1, 3);
            repeat (n) q = {q, 8'($urandom_range(0, 255))};
          end
          default: push_unit(q, 16'(pick_bmp()), be);
        endcase
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) q = {q, 8'($urandom_range(0, 255))};
      end
    endcase
  endfunction

  initial begin : stimulus
    byte_q_t seq;
    mode_e   mode;
    int      phase_start;
    int      burst_end;
    bit      paused;
    rst_ni                = 1'b0;
    byte_ch.valid         = 1'b0;
    byte_ch.byte_value    = '0;
    byte_ch.byte_present  = 1'b0;
    byte_ch.end_of_stream = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // UTF-8: leading BOM dropped, bad continuation decoded again, extremes, flush
    start_stream(MODE_UTF8, 1'b0);
    seq = {8'hEF, 8'hBB, 8'hBF};
    send_seq(seq, 1'b0);
    seq = {8'hC3, 8'h41};
    send_seq(seq, 1'b0);
    seq = {8'hF0, 8'h90, 8'h80, 8'h80};
    send_seq(seq, 1'b0);
    seq = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_seq(seq, 1'b0);
    seq = {8'hE2, 8'h82};
    send_seq(seq, 1'b1);
    seq = {8'hFF, 8'h00};
    send_seq(seq, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);

    // UTF-16LE: BOM dropped, unpaired lead then a plain unit, lone trail, held byte flush
    start_stream(MODE_UTF16LE, 1'b0);
    seq = {8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h41, 8'h00, 8'h00, 8'hDC};
    send_seq(seq, 1'b0);
    send_byte(8'h41, 1'b1, 1'b1);

    // x-user-defined: high bytes map into the private use area
    start_stream(MODE_USER, 1'b0);
    seq = {8'h80, 8'hFF};
    send_seq(seq, 1'b0);

    // random traffic under every mode, with and without BOM stripping
    for (int p = 0; p < NumPhases; p++) begin
      mode = mode_e'(p % 4);
      start_stream(mode, p >= 4);
      phase_start = bytes_sent;
      paused      = 1'b0;
      burst_end   = phase_start;
      if (p == 2) begin
        // receiver holds off while bytes keep coming, so the result queue fills
        rx_hold   = HoldOff;
        burst_end = phase_start + 40;
      end
      while (bytes_sent - phase_start < PhaseBytes) begin
        if (!paused && bytes_sent - phase_start >= PhaseBytes / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        seq.delete();
        make_chunk(mode, seq);
        tx_eager = (bytes_sent < burst_end) || ($urandom_range(0, 4) == 0);
        send_seq(seq, $urandom_range(0, 11) == 0);
        if ($urandom_range(0, 19) == 0)
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS unicode_byte_stream_decoder");
    end else begin
      $display("FAIL unicode_byte_stream_decoder");
    end
    $finish;
  end

endmodule
